// ===== rtl/poi_pkg.sv =====
// Shared constants, types and the arctangent table for the odometry integrator.
package poi_pkg;

    // CORDIC iteration count, clipped to the table length
    localparam int CORDIC_STEPS = 18;
    localparam int CorN = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // CORDIC datapath width, Q2.30 plus guard bits
    localparam int CW = 34;

    // Bit-serial multiplier: multiplicand width, multiplier width, product width
    localparam int MA = 38;
    localparam int MB = 25;
    localparam int MP = MA + MB;

    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER      = 34'sd1073741824;
    localparam logic signed [CW-1:0] NEG_QUARTER  = -34'sd1073741824;
    localparam logic signed [CW-1:0] HALF         = 34'sd2147483648;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cor_req;

    typedef struct packed {
        logic                 start;
        logic signed [MA-1:0] a;
        logic signed [MB-1:0] b;
    } t_mul_req;

    // atan(2^-i) as a binary angle, full turn = 2^32
    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/poi_if.sv =====
// Valid/ready channel interfaces for tick input beats and pose result beats.
interface poi_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] yaw_rate;
    logic        [23:0] elapsed;

    modport source (output valid, output vel_x, output vel_y, output yaw_rate,
                    output elapsed, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input yaw_rate,
                    input elapsed, output ready);
endinterface

interface poi_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [17:0] quat_z;
    logic signed [17:0] quat_w;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output quat_z, output quat_w, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input quat_z, input quat_w, output ready);
endinterface

// ===== rtl/poi_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module poi_cordic (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  poi_pkg::t_cor_req            i_req,
    output logic                         o_busy,
    output logic signed [poi_pkg::CW-1:0] o_cos,
    output logic signed [poi_pkg::CW-1:0] o_sin
);
    import poi_pkg::*;

    logic                 r_busy;
    logic [4:0]           r_i;
    logic                 r_neg;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_a;

    logic signed [CW-1:0] w_a0;
    logic signed [CW-1:0] w_a_red;
    logic                 w_neg;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] w_atan;

    // fold the angle into +-quarter turn; negate outputs at the end
    always_comb begin
        w_a0 = {{(CW-32){i_req.angle[31]}}, i_req.angle};
        w_a_red = w_a0;
        w_neg = 1'b0;
        if (w_a0 > QUARTER) begin
            w_a_red = w_a0 - HALF;
            w_neg = 1'b1;
        end else if (w_a0 < NEG_QUARTER) begin
            w_a_red = w_a0 + HALF;
            w_neg = 1'b1;
        end
    end

    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = atan_lut(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_i == 5'(CorN - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= CORDIC_START;
            r_y   <= '0;
            r_a   <= w_a_red;
            r_neg <= w_neg;
            r_i   <= '0;
        end else if (r_busy) begin
            if (!r_a[CW-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_a <= r_a - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_a <= r_a + w_atan;
            end
            r_i <= r_i + 5'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== rtl/poi_smul.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module poi_smul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  poi_pkg::t_mul_req             i_req,
    output logic                          o_busy,
    output logic signed [poi_pkg::MP-1:0] o_prod
);
    import poi_pkg::*;

    localparam int HW = MA + 2;
    localparam int KW = $clog2(MB);

    logic                 r_busy;
    logic [KW-1:0]        r_k;
    logic signed [MA-1:0] r_a;
    logic signed [HW-1:0] r_h;
    logic [MB-1:0]        r_l;

    logic signed [HW-1:0] w_aext;
    logic signed [HW-1:0] w_add;
    logic signed [HW-1:0] w_sum;
    logic                 w_last;

    assign w_last = (r_k == KW'(MB - 1));
    assign w_aext = HW'(r_a);

    // multiplier MSB carries negative weight
    always_comb begin
        if (!r_l[0]) begin
            w_add = '0;
        end else if (w_last) begin
            w_add = -w_aext;
        end else begin
            w_add = w_aext;
        end
        w_sum = r_h + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_h <= '0;
            r_l <= i_req.b;
            r_k <= '0;
        end else if (r_busy) begin
            r_h <= {w_sum[HW-1], w_sum[HW-1:1]};
            r_l <= {w_sum[0], r_l[MB-1:1]};
            r_k <= r_k + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_h[MA-1:0], r_l};

endmodule

// ===== rtl/planar_odometry_integrator.sv =====
// Top level: dead-reckoning pose integrator with bit-serial arithmetic.
//
// Each accepted tick beat (body velocities, yaw rate, elapsed time) yields one
// pose beat: saturated world x/y in Q24.24, heading as a 32-bit binary angle,
// and the yaw quaternion z/w (sine/cosine of half heading, Q1.16). The
// velocity is rotated by the heading held before the tick, then the heading
// advances by yaw_rate * elapsed. A tick goes from acceptance to the next
// acceptance, when the result beat is taken at once, through the accept
// step, four passes of the bit-serial multipliers, the two multiplier
// launches and the pose write; the two 18-step CORDIC runs overlap the
// multiplier passes. The result sits in an output register, so the block
// returns to idle while it waits to be taken; a new tick is accepted then,
// and only its final pose write waits for the output register to drain.
// tick ready is high only while idle.
module planar_odometry_integrator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    poi_in_if.sink    i_in,
    poi_out_if.source o_out
);
    import poi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ROT    = 8'b0000_0010,
        S_LAUNCH = 8'b0000_0100,
        S_M1     = 8'b0000_1000,
        S_M2     = 8'b0001_0000,
        S_L2     = 8'b0010_0000,
        S_M3     = 8'b0100_0000,
        S_POS    = 8'b1000_0000
    } t_state;

    localparam int DW = MP - 24;   // rounded position step width
    localparam logic signed [19:0] Q_LIM     = 20'sd65536;
    localparam logic signed [19:0] Q_NEG_LIM = -20'sd65536;

    t_state r_state, n_state;

    // pose state
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic [31:0]        r_head;

    // latched tick
    logic signed [23:0] r_vx;
    logic signed [23:0] r_vy;
    logic [23:0]        r_dt;

    // intermediate terms
    logic signed [CW-1:0] r_c;
    logic signed [CW-1:0] r_s;
    logic signed [MP-1:0] r_pa;
    logic signed [MP-1:0] r_pb;
    logic signed [MP:0]   r_sx;
    logic signed [MP:0]   r_sy;
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;

    // output register
    logic               r_ovalid;
    logic signed [47:0] r_opx;
    logic signed [47:0] r_opy;
    logic [31:0]        r_ohead;
    logic signed [17:0] r_oqz;
    logic signed [17:0] r_oqw;

    // unit hookups
    t_cor_req             w_creq;
    t_mul_req             w_mreq_a;
    t_mul_req             w_mreq_b;
    logic                 w_cor_busy;
    logic                 w_mul_a_busy;
    logic                 w_mul_b_busy;
    logic signed [CW-1:0] w_cos;
    logic signed [CW-1:0] w_sin;
    logic signed [MP-1:0] w_prod_a;
    logic signed [MP-1:0] w_prod_b;

    logic                 w_muls_idle;
    logic                 w_load;
    logic [MP-1:0]        w_dh_sum;
    logic [MP:0]          w_wx_sum;
    logic [MP:0]          w_wy_sum;
    logic signed [MA-1:0] w_wx;
    logic signed [MA-1:0] w_wy;
    logic [MP-1:0]        w_dx_sum;
    logic [MP-1:0]        w_dy_sum;
    logic signed [48:0]   w_px_sum;
    logic signed [48:0]   w_py_sum;
    logic signed [47:0]   w_px_sat;
    logic signed [47:0]   w_py_sat;
    logic [CW-1:0]        w_qc_sum;
    logic [CW-1:0]        w_qs_sum;
    logic signed [19:0]   w_qw_r;
    logic signed [19:0]   w_qz_r;
    logic signed [17:0]   w_qw;
    logic signed [17:0]   w_qz;

    poi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .o_busy  (w_cor_busy),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    poi_smul u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq_a),
        .o_busy  (w_mul_a_busy),
        .o_prod  (w_prod_a)
    );

    poi_smul u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq_b),
        .o_busy  (w_mul_b_busy),
        .o_prod  (w_prod_b)
    );

    assign w_muls_idle = !w_mul_a_busy && !w_mul_b_busy;

    // heading step: rnd(yaw_rate * elapsed, 8), kept modulo a full turn
    assign w_dh_sum = w_prod_b + MP'(128);

    // world-frame velocity: rnd(sum, 22)
    assign w_wx_sum = r_sx + (MP+1)'(2**21);
    assign w_wy_sum = r_sy + (MP+1)'(2**21);
    assign w_wx     = w_wx_sum[MA+21:22];
    assign w_wy     = w_wy_sum[MA+21:22];

    // position step: rnd(w * elapsed, 24)
    assign w_dx_sum = w_prod_a + MP'(2**23);
    assign w_dy_sum = w_prod_b + MP'(2**23);

    // saturating position add: overflow shows as the top two bits disagreeing
    assign w_px_sum = 49'(r_x) + 49'(r_dx);
    assign w_py_sum = 49'(r_y) + 49'(r_dy);
    always_comb begin
        if (w_px_sum[48] != w_px_sum[47]) begin
            w_px_sat = w_px_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            w_px_sat = w_px_sum[47:0];
        end
        if (w_py_sum[48] != w_py_sum[47]) begin
            w_py_sat = w_py_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            w_py_sat = w_py_sum[47:0];
        end
    end

    // quaternion: rnd(., 14) to Q1.16, clamped to +-1
    assign w_qc_sum = w_cos + CW'(8192);
    assign w_qs_sum = w_sin + CW'(8192);
    assign w_qw_r   = w_qc_sum[CW-1:14];
    assign w_qz_r   = w_qs_sum[CW-1:14];
    always_comb begin
        if (w_qw_r > Q_LIM) begin
            w_qw = 18'(Q_LIM);
        end else if (w_qw_r < Q_NEG_LIM) begin
            w_qw = 18'(Q_NEG_LIM);
        end else begin
            w_qw = w_qw_r[17:0];
        end
        if (w_qz_r > Q_LIM) begin
            w_qz = 18'(Q_LIM);
        end else if (w_qz_r < Q_NEG_LIM) begin
            w_qz = 18'(Q_NEG_LIM);
        end else begin
            w_qz = w_qz_r[17:0];
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        w_creq   = '0;
        w_mreq_a = '0;
        w_mreq_b = '0;
        w_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // sin/cos of the old heading alongside yaw_rate * elapsed
                    w_creq.start   = 1'b1;
                    w_creq.angle   = r_head;
                    w_mreq_b.start = 1'b1;
                    w_mreq_b.a     = MA'(i_in.yaw_rate);
                    w_mreq_b.b     = {1'b0, i_in.elapsed};
                    n_state        = S_ROT;
                end
            end
            S_ROT: begin
                if (!w_cor_busy && !w_mul_b_busy) begin
                    n_state = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                // quaternion CORDIC on the new half heading runs in the shadow
                w_creq.start   = 1'b1;
                w_creq.angle   = {1'b0, r_head[31:1]};
                w_mreq_a.start = 1'b1;
                w_mreq_a.a     = MA'(r_c);
                w_mreq_a.b     = MB'(r_vx);
                w_mreq_b.start = 1'b1;
                w_mreq_b.a     = MA'(r_s);
                w_mreq_b.b     = MB'(r_vx);
                n_state        = S_M1;
            end
            S_M1: begin
                if (w_muls_idle) begin
                    w_mreq_a.start = 1'b1;
                    w_mreq_a.a     = MA'(r_s);
                    w_mreq_a.b     = MB'(r_vy);
                    w_mreq_b.start = 1'b1;
                    w_mreq_b.a     = MA'(r_c);
                    w_mreq_b.b     = MB'(r_vy);
                    n_state        = S_M2;
                end
            end
            S_M2: begin
                if (w_muls_idle) begin
                    n_state = S_L2;
                end
            end
            S_L2: begin
                w_mreq_a.start = 1'b1;
                w_mreq_a.a     = w_wx;
                w_mreq_a.b     = {1'b0, r_dt};
                w_mreq_b.start = 1'b1;
                w_mreq_b.a     = w_wy;
                w_mreq_b.b     = {1'b0, r_dt};
                n_state        = S_M3;
            end
            S_M3: begin
                if (w_muls_idle) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (!r_ovalid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_ROT) && (n_state == S_LAUNCH)) begin
                r_head <= r_head + w_dh_sum[39:8];
            end
            if (w_load) begin
                r_x <= w_px_sat;
                r_y <= w_py_sat;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_vx <= i_in.vel_x;
            r_vy <= i_in.vel_y;
            r_dt <= i_in.elapsed;
        end
        if ((r_state == S_ROT) && (n_state == S_LAUNCH)) begin
            r_c <= w_cos;
            r_s <= w_sin;
        end
        if ((r_state == S_M1) && w_muls_idle) begin
            r_pa <= w_prod_a;   // vx * c
            r_pb <= w_prod_b;   // vx * s
        end
        if ((r_state == S_M2) && w_muls_idle) begin
            r_sx <= (MP+1)'(r_pa) - (MP+1)'(w_prod_a);
            r_sy <= (MP+1)'(r_pb) + (MP+1)'(w_prod_b);
        end
        if ((r_state == S_M3) && w_muls_idle) begin
            r_dx <= w_dx_sum[MP-1:24];
            r_dy <= w_dy_sum[MP-1:24];
        end
        if (w_load) begin
            r_opx   <= w_px_sat;
            r_opy   <= w_py_sat;
            r_ohead <= r_head;
            r_oqz   <= w_qz;
            r_oqw   <= w_qw;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ovalid;
    assign o_out.pos_x   = r_opx;
    assign o_out.pos_y   = r_opy;
    assign o_out.heading = r_ohead;
    assign o_out.quat_z  = r_oqz;
    assign o_out.quat_w  = r_oqw;

    // an accepted tick starts the first CORDIC and the heading multiply
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_cor_busy && w_mul_b_busy))
        else $error("tick accepted without starting rotation units");

    // heading moves only at the end of the rotation phase
    a_head_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_head)) |-> ($past(r_state) == S_ROT))
        else $error("heading changed outside rotation phase");

    // a new result beat comes only from the pose write
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_ovalid)) |-> ($past(r_state) == S_POS))
        else $error("result beat raised outside pose write");

    // the pose write sees every arithmetic unit finished
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> (!w_cor_busy && w_muls_idle))
        else $error("pose write while a unit is still busy");

endmodule
